// File: design/tep_pkg.sv
// Shared types and constants of the tree ensemble predictor.
// Holds beat payloads, table words and controller/datapath command structs.
package tep_pkg;

  localparam int NodeAddrW = 10;
  localparam int NodeDepth = 1 << NodeAddrW;
  localparam int FeatW     = 8;
  localparam int FeatDepth = 1 << FeatW;
  localparam int TreeIdxW  = 8;
  localparam int TreeDepth = 1 << TreeIdxW;
  localparam int GroupW    = 4;
  localparam int GroupDepth = 1 << GroupW;
  localparam int ValW      = 32;
  localparam int CfgIdxW   = 2;

  typedef enum logic [1:0] {
    KIND_NODE  = 2'd0,
    KIND_TREE  = 2'd1,
    KIND_ENTRY = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NUM_TREES  = 2'd0,
    CFG_NUM_GROUPS = 2'd1,
    CFG_BIAS       = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]           kind;
    logic [NodeAddrW-1:0] node_addr;
    logic [FeatW-1:0]     feature_index;
    logic                 default_left;
    logic                 is_leaf;
    logic [NodeAddrW-1:0] left_child;
    logic [NodeAddrW-1:0] right_child;
    logic signed [ValW-1:0] value;
    logic [TreeIdxW-1:0]  tree_index;
    logic [NodeAddrW-1:0] tree_base;
    logic [GroupW-1:0]    tree_grp;
    logic                 last_entry;
  } in_item_t;

  typedef struct packed {
    logic [GroupW-1:0]      group;
    logic signed [ValW-1:0] prediction;
    logic                   last;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [ValW-1:0]    data;
  } cfg_item_t;

  typedef struct packed {
    logic [FeatW-1:0]       feat;
    logic                   dleft;
    logic                   leaf;
    logic [NodeAddrW-1:0]   left;
    logic [NodeAddrW-1:0]   right;
    logic signed [ValW-1:0] val;
  } node_word_t;

  typedef struct packed {
    logic [NodeAddrW-1:0] base;
    logic [GroupW-1:0]    grp;
  } tree_word_t;

  typedef struct packed {
    logic init_wr;
    logic g_clr;
    logic g_inc;
    logic t_clr;
    logic t_inc;
    logic tree_take;
    logic node_take;
    logic feat_step;
    logic walk_zero;
    logic sum_sel_g;
    logic sum_wr;
    logic out_take;
    logic present_clr;
  } cmd_t;

  typedef struct packed {
    logic eval_start;
    logic g_last;
    logic t_done;
    logic grp_skip;
    logic is_leaf;
    logic step_last;
  } stat_t;

endpackage

// File: design/tep_chan_if.sv
// Valid/ready channel carrying one payload beat.
// Payload type is a parameter; uses no package items.
interface tep_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/tep_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
module tep_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: design/tep_datapath.sv
// Datapath: table RAMs, present marks, config registers, walk and sum logic.
// Depends on tep_pkg and tep_ram; driven by tep_ctrl commands.
module tep_datapath import tep_pkg::*; #(
  parameter int MAX_NODES    = 1024,
  parameter int MAX_TREES    = 256,
  parameter int MAX_FEATURES = 256,
  parameter int MAX_GROUPS   = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_fire_i,
  input  in_item_t  in_item_i,
  input  logic      cfg_fire_i,
  input  cfg_item_t cfg_item_i,
  input  cmd_t      cmd_i,
  output stat_t     stat_o,
  output out_item_t out_item_o
);
  localparam int StepW      = $clog2(MAX_NODES);
  localparam int GroupLimit = (MAX_GROUPS < GroupDepth) ? MAX_GROUPS : GroupDepth;

  logic [8:0]            num_trees_q;
  logic [4:0]            num_groups_q;
  logic signed [ValW-1:0] base_q;
  logic [FeatDepth-1:0]  present_q;
  logic [GroupW-1:0]     g_q;
  logic [8:0]            t_q;
  logic [NodeAddrW-1:0]  addr_q, root_q;
  logic [StepW-1:0]      steps_q;
  logic [GroupW-1:0]     grp_q;
  logic signed [ValW-1:0] weight_q;
  node_word_t            node_q;
  out_item_t             out_q;

  node_word_t node_rd, node_wr;
  tree_word_t tree_rd, tree_wr;
  logic [ValW-1:0] row_rd, sum_rd;
  logic [ValW-1:0] sum_wdata;
  logic [GroupW-1:0] sum_raddr, sum_waddr;
  logic [4:0] gcnt;
  logic [GroupW-1:0] eff_grp;
  logic present, go_left;
  logic [NodeAddrW-1:0] child;
  logic [ValW:0] sum_ext;
  logic signed [ValW-1:0] sat;
  logic node_we, tree_we, row_we;

  always_comb begin
    if (num_groups_q == 5'd0) begin
      gcnt = 5'd1;
    end else if (32'(num_groups_q) > GroupLimit) begin
      gcnt = 5'(GroupLimit);
    end else begin
      gcnt = num_groups_q;
    end
  end

  assign node_we = in_fire_i && (in_item_i.kind == KIND_NODE);
  assign tree_we = in_fire_i && (in_item_i.kind == KIND_TREE) &&
                   (32'(in_item_i.tree_index) < MAX_TREES);
  assign row_we  = in_fire_i && (in_item_i.kind == KIND_ENTRY) &&
                   (32'(in_item_i.feature_index) < MAX_FEATURES);

  assign node_wr = '{feat: in_item_i.feature_index, dleft: in_item_i.default_left,
                     leaf: in_item_i.is_leaf, left: in_item_i.left_child,
                     right: in_item_i.right_child, val: in_item_i.value};
  assign tree_wr = '{base: in_item_i.tree_base, grp: in_item_i.tree_grp};

  tep_ram #(.WIDTH($bits(node_word_t)), .DEPTH(NodeDepth)) u_node_ram (
    .clk_i, .we_i(node_we), .waddr_i(in_item_i.node_addr), .wdata_i(node_wr),
    .raddr_i(addr_q), .rdata_o(node_rd));

  tep_ram #(.WIDTH($bits(tree_word_t)), .DEPTH(TreeDepth)) u_tree_ram (
    .clk_i, .we_i(tree_we), .waddr_i(in_item_i.tree_index), .wdata_i(tree_wr),
    .raddr_i(t_q[TreeIdxW-1:0]), .rdata_o(tree_rd));

  tep_ram #(.WIDTH(ValW), .DEPTH(FeatDepth)) u_row_ram (
    .clk_i, .we_i(row_we), .waddr_i(in_item_i.feature_index), .wdata_i(in_item_i.value),
    .raddr_i(node_rd.feat), .rdata_o(row_rd));

  assign sum_raddr = cmd_i.sum_sel_g ? g_q : grp_q;
  assign sum_waddr = cmd_i.init_wr ? g_q : grp_q;
  assign sum_ext   = {sum_rd[ValW-1], sum_rd} + {weight_q[ValW-1], weight_q};
  always_comb begin
    if (sum_ext[ValW] != sum_ext[ValW-1]) begin
      sat = sum_ext[ValW] ? {1'b1, {(ValW-1){1'b0}}} : {1'b0, {(ValW-1){1'b1}}};
    end else begin
      sat = sum_ext[ValW-1:0];
    end
  end
  assign sum_wdata = cmd_i.init_wr ? base_q : sat;

  tep_ram #(.WIDTH(ValW), .DEPTH(GroupDepth)) u_sum_ram (
    .clk_i, .we_i(cmd_i.init_wr || cmd_i.sum_wr), .waddr_i(sum_waddr),
    .wdata_i(sum_wdata), .raddr_i(sum_raddr), .rdata_o(sum_rd));

  assign eff_grp = (gcnt == 5'd1) ? '0 : tree_rd.grp;
  assign present = (32'(node_q.feat) < MAX_FEATURES) && present_q[node_q.feat];
  assign go_left = present ? ($signed(row_rd) < node_q.val) : node_q.dleft;
  assign child   = go_left ? node_q.left : node_q.right;

  assign stat_o.eval_start = in_fire_i && ((in_item_i.kind == KIND_EMPTY) ||
                             ((in_item_i.kind == KIND_ENTRY) && in_item_i.last_entry));
  assign stat_o.g_last    = ({1'b0, g_q} == (gcnt - 5'd1));
  assign stat_o.t_done    = (32'(t_q) >= 32'(num_trees_q)) || (32'(t_q) >= MAX_TREES);
  assign stat_o.grp_skip  = ({1'b0, eff_grp} >= gcnt);
  assign stat_o.is_leaf   = node_rd.leaf;
  assign stat_o.step_last = (steps_q == StepW'(MAX_NODES - 1));

  assign out_item_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_trees_q  <= 9'd1;
      num_groups_q <= 5'd1;
      base_q       <= 32'sd32768;
      present_q    <= '0;
      g_q          <= '0;
      t_q          <= '0;
    end else begin
      if (cfg_fire_i) begin
        case (cfg_item_i.index)
          CFG_NUM_TREES:  num_trees_q  <= cfg_item_i.data[8:0];
          CFG_NUM_GROUPS: num_groups_q <= cfg_item_i.data[4:0];
          CFG_BIAS:       base_q       <= cfg_item_i.data;
          default: ;
        endcase
      end
      if (cmd_i.present_clr) begin
        present_q <= '0;
      end else if (row_we) begin
        present_q[in_item_i.feature_index] <= 1'b1;
      end
      if (cmd_i.g_clr) begin
        g_q <= '0;
      end else if (cmd_i.g_inc) begin
        g_q <= g_q + 1'b1;
      end
      if (cmd_i.t_clr) begin
        t_q <= '0;
      end else if (cmd_i.t_inc) begin
        t_q <= t_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tree_take) begin
      root_q  <= tree_rd.base;
      addr_q  <= tree_rd.base;
      grp_q   <= eff_grp;
      steps_q <= '0;
    end
    if (cmd_i.node_take) begin
      node_q <= node_rd;
      if (node_rd.leaf) begin
        weight_q <= node_rd.val;
      end
    end
    if (cmd_i.feat_step) begin
      addr_q  <= root_q + child;
      steps_q <= steps_q + 1'b1;
    end
    if (cmd_i.walk_zero) begin
      weight_q <= '0;
    end
    if (cmd_i.out_take) begin
      out_q.group      <= g_q;
      out_q.prediction <= sum_rd;
      out_q.last       <= stat_o.g_last;
    end
  end
endmodule

// File: design/tep_ctrl.sv
// Controller state machine: row accept, group init, tree walks, result beats.
// Depends on tep_pkg; drives tep_datapath through cmd_t and reads stat_t.
module tep_ctrl import tep_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  input  logic  out_ready_i,
  output cmd_t  cmd_o,
  output logic  in_ready_o,
  output logic  out_valid_o
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INIT  = 4'd1;
  localparam logic [3:0] S_TREE  = 4'd2;
  localparam logic [3:0] S_TWAIT = 4'd3;
  localparam logic [3:0] S_NRD   = 4'd4;
  localparam logic [3:0] S_NWAIT = 4'd5;
  localparam logic [3:0] S_FWAIT = 4'd6;
  localparam logic [3:0] S_SRD   = 4'd7;
  localparam logic [3:0] S_SWAIT = 4'd8;
  localparam logic [3:0] S_ORD   = 4'd9;
  localparam logic [3:0] S_OWAIT = 4'd10;
  localparam logic [3:0] S_OHOLD = 4'd11;

  logic [3:0] state_q, state_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OHOLD);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.t_clr = 1'b1;
        if (stat_i.eval_start) state_d = S_INIT;
      end
      S_INIT: begin
        cmd_o.init_wr = 1'b1;
        if (stat_i.g_last) begin
          cmd_o.g_clr = 1'b1;
          state_d = S_TREE;
        end else begin
          cmd_o.g_inc = 1'b1;
        end
      end
      S_TREE: state_d = stat_i.t_done ? S_ORD : S_TWAIT;
      S_TWAIT: begin
        cmd_o.tree_take = 1'b1;
        if (stat_i.grp_skip) begin
          cmd_o.t_inc = 1'b1;
          state_d = S_TREE;
        end else begin
          state_d = S_NRD;
        end
      end
      S_NRD: state_d = S_NWAIT;
      S_NWAIT: begin
        cmd_o.node_take = 1'b1;
        state_d = stat_i.is_leaf ? S_SRD : S_FWAIT;
      end
      S_FWAIT: begin
        cmd_o.feat_step = 1'b1;
        if (stat_i.step_last) begin
          cmd_o.walk_zero = 1'b1;
          state_d = S_SRD;
        end else begin
          state_d = S_NRD;
        end
      end
      S_SRD: state_d = S_SWAIT;
      S_SWAIT: begin
        cmd_o.sum_wr = 1'b1;
        cmd_o.t_inc  = 1'b1;
        state_d = S_TREE;
      end
      S_ORD: begin
        cmd_o.sum_sel_g = 1'b1;
        state_d = S_OWAIT;
      end
      S_OWAIT: begin
        cmd_o.out_take = 1'b1;
        state_d = S_OHOLD;
      end
      S_OHOLD: begin
        if (out_ready_i) begin
          if (stat_i.g_last) begin
            cmd_o.g_clr       = 1'b1;
            cmd_o.present_clr = 1'b1;
            state_d = S_IDLE;
          end else begin
            cmd_o.g_inc = 1'b1;
            state_d = S_ORD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef ASSERT_OFF
  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("input ready during result beat");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ready_o && stat_i.eval_start) |=> !in_ready_o)
    else $error("row end did not start evaluation");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && stat_i.g_last) |=> in_ready_o)
    else $error("not idle after final result beat");
  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result beat dropped while stalled");
`endif
endmodule

// File: design/tree_ensemble_predictor.sv
// Boosted-tree ensemble predictor, top level.
// Depends on tep_pkg, tep_chan_if, tep_ctrl and tep_datapath.
//
// Usage:
//   in_chan  carries items: node writes, tree descriptor writes, feature
//            entries and empty-row markers. Table writes and entries without
//            last_entry are taken without leaving the idle state.
//   cfg_chan writes num_trees, num_groups and the bias by index; always ready.
//   out_chan gives one beat per group in group order, last set on the final.
// Sequence of a row end: each group's sum is set to the bias, then each
//   evaluated tree reads its descriptor, walks its inner nodes, reads its leaf
//   and adds the leaf value to its group's sum with saturation (skipped trees
//   add nothing; a walk cut off after MAX_NODES inner nodes adds zero), the end
//   of the tree list is found, then one result beat per group is given.
// in_chan is not ready from a row end until the final result beat is taken.
// A stalled receiver holds the current result beat in the output register.
// Reset clears present marks and control state and loads register defaults;
//   table contents are undefined until written.
module tree_ensemble_predictor import tep_pkg::*; #(
  parameter int MAX_NODES    = 1024,
  parameter int MAX_TREES    = 256,
  parameter int MAX_FEATURES = 256,
  parameter int MAX_GROUPS   = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  tep_chan_if.sink   in_chan,
  tep_chan_if.sink   cfg_chan,
  tep_chan_if.source out_chan
);
  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;
  logic  in_fire;

  assign in_chan.ready  = in_ready;
  assign in_fire        = in_chan.valid && in_ready;
  assign cfg_chan.ready = 1'b1;

  tep_ctrl u_ctrl (
    .clk_i, .rst_ni, .stat_i(stat), .out_ready_i(out_chan.ready),
    .cmd_o(cmd), .in_ready_o(in_ready), .out_valid_o(out_chan.valid));

  tep_datapath #(
    .MAX_NODES(MAX_NODES), .MAX_TREES(MAX_TREES),
    .MAX_FEATURES(MAX_FEATURES), .MAX_GROUPS(MAX_GROUPS)
  ) u_datapath (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .in_item_i(in_chan.data),
    .cfg_fire_i(cfg_chan.valid), .cfg_item_i(cfg_chan.data),
    .cmd_i(cmd), .stat_o(stat), .out_item_o(out_chan.data));
endmodule
